### src/tolerance_window_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// tolerance_window_matcher_top_macros
// Assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef TOLERANCE_WINDOW_MATCHER_TOP_MACROS_SVH
`define TOLERANCE_WINDOW_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### src/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// Shared widths, codes and types of the tolerance window matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package twm_pkg;

  localparam int LEVEL_W  = 32;
  localparam int TOL_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int SLOT_W   = 4;
  localparam int CODE_W   = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int PERCENT_UNIT = 100;
  localparam int BAND_DIVISOR = PERCENT_UNIT * PERCENT_UNIT;

  // query * {0,tol}: signed product
  localparam int PROD_W   = LEVEL_W + TOL_W + 1;
  localparam int DIFF_W   = LEVEL_W + 1;
  localparam int SCALED_W = PROD_W - 1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [TOL_W-1:0]   tol;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic load_level;
    logic load_band;
  } scan_ctrl_t;

endpackage

`default_nettype wire

### src/tolerance_window_matcher_top.sv
// ----------------------------------------------------------------------------
// tolerance_window_matcher_top
// Reference-level table with first-match tolerance classification.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers when start is high and busy is low.
//   kind selects a table write (slot, level) or a query (level).
//   A write stores the level, gives no result and leaves busy low, so
//   commands may follow back to back.
//   A query holds busy while a state forms the scaled band and then one
//   table entry is read from the RAM and tested per cycle, for at most
//   min(entry_count, TABLE_DEPTH) entries. The walk stops at the first hit.
//   done pulses for one cycle with match_code in the cycle in which busy
//   falls; a new item can transfer in that same cycle. The receiver cannot
//   stall; each result is valid for that single cycle only.
//   The user must write configuration over APB only while the block is idle;
//   the block itself does not enforce this.
//   Reset clears the configuration registers, state and done; table contents
//   stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module tolerance_window_matcher_top import twm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [SLOT_W-1:0]         slot,
  input  logic signed [LEVEL_W-1:0] level,
  output logic                      done,
  output logic [CODE_W-1:0]         match_code
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BAND = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  cfg_t               cfg;
  scan_ctrl_t         ctrl;
  logic               accept;
  logic               wr_en;
  logic               hit;
  logic [AW-1:0]      raddr;
  logic [LEVEL_W-1:0] ref_level;

  logic [1:0]         state, state_next;
  logic [COUNT_W-1:0] idx, idx_next;
  logic [COUNT_W-1:0] limit, limit_next;
  logic               done_next;
  logic [CODE_W-1:0]  code_next;

  twm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (kind == KIND_WRITE) && (int'(slot) < TABLE_DEPTH);

  // entry idx is on rdata during a scan cycle, so fetch idx + 1 ahead
  assign raddr = (state == ST_SCAN) ? AW'(idx + COUNT_W'(1)) : '0;

  twm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(slot)),
    .wdata (level),
    .raddr (raddr),
    .rdata (ref_level)
  );

  assign ctrl.load_level = accept && (kind == KIND_QUERY);
  assign ctrl.load_band  = (state == ST_BAND);

  twm_scan u_scan (
    .clk       (clk),
    .ctrl      (ctrl),
    .level_in  (level),
    .tol       (cfg.tol),
    .ref_level (ref_level),
    .hit       (hit)
  );

  always_comb begin
    state_next = state;
    idx_next   = idx;
    limit_next = limit;
    done_next  = 1'b0;
    code_next  = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_QUERY)) begin
          state_next = ST_BAND;
          idx_next   = '0;
          limit_next = (int'(cfg.count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH)
                                                       : cfg.count;
        end
      end
      ST_BAND: begin
        if (limit == '0) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
          code_next  = CODE_W'(idx) + CODE_W'(1);
        end else if (idx == limit - COUNT_W'(1)) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end else begin
          idx_next = idx + COUNT_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    limit <= limit_next;
    if (done_next) begin
      match_code <= code_next;
    end
  end

endmodule

`default_nettype wire

### src/twm_ram.sv
// ----------------------------------------------------------------------------
// twm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/twm_regs.sv
// ----------------------------------------------------------------------------
// twm_regs
// APB register file: tolerance and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module twm_regs import twm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TOL:   cfg.tol   <= pwdata[TOL_W-1:0];
        REG_COUNT: cfg.count <= pwdata[COUNT_W-1:0];
        default:   cfg       <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOL:   prdata = PDATA_W'(cfg.tol);
      REG_COUNT: prdata = PDATA_W'(cfg.count);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/twm_scan.sv
// ----------------------------------------------------------------------------
// twm_scan
// Query datapath: holds the query, forms the scaled band, tests one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module twm_scan import twm_pkg::*; (
  input  logic               clk,
  input  scan_ctrl_t         ctrl,
  input  logic [LEVEL_W-1:0] level_in,
  input  logic [TOL_W-1:0]   tol,
  input  logic [LEVEL_W-1:0] ref_level,
  output logic               hit
);

  logic signed [LEVEL_W-1:0] query;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W-1:0]  diff;
  logic        [DIFF_W-1:0]  mag;
  logic        [SCALED_W-1:0] need;

  always_ff @(posedge clk) begin
    if (ctrl.load_level) begin
      query <= $signed(level_in);
    end
    if (ctrl.load_band) begin
      prod <= PROD_W'(query) * PROD_W'($signed({1'b0, tol}));
    end
  end

  // |v - r| < trunc(p / D)  <=>  (|v - r| + 1) * D <= p, so no divider.
  // A non-positive product never matches.
  always_comb begin
    diff = DIFF_W'(query) - DIFF_W'($signed(ref_level));
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    need = (SCALED_W'(mag) + SCALED_W'(1)) * SCALED_W'(BAND_DIVISOR);
    hit  = !prod[PROD_W-1] && (need <= prod[SCALED_W-1:0]);
  end

endmodule

`default_nettype wire

### src/twm_chk.sv
// ----------------------------------------------------------------------------
// twm_chk
// Port-level checks on the command and result behavior of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tolerance_window_matcher_top_macros.svh"

module twm_chk import twm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              kind,
  input logic              done,
  input logic [CODE_W-1:0] match_code
);

  // code never points past the table
  `TWM_ASSERT_NOW(a_code_range, done, int'(match_code) <= TABLE_DEPTH)

  // a query transfer always occupies the block
  `TWM_ASSERT_NEXT(a_query_busy, start && !busy && kind == KIND_QUERY, busy)

  // a write transfer completes at once and yields nothing
  `TWM_ASSERT_NEXT(a_write_silent, start && !busy && kind == KIND_WRITE, !busy && !done)

  // a query ends with exactly its result strobe
  `TWM_ASSERT_NOW(a_done_ends_busy, !$past(rst) && $fell(busy), done)

endmodule

bind tolerance_window_matcher_top twm_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (.*);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tolerance window matcher: table writes and
// queries go in over the start/busy channel, tolerance and entry count over
// APB, and every done pulse is checked against a local first-match predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import twm_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 50;

  localparam logic [PADDR_W-1:0] ADDR_TOL   = PADDR_W'(4 * REG_TOL);
  localparam logic [PADDR_W-1:0] ADDR_COUNT = PADDR_W'(4 * REG_COUNT);

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      start;
  logic                      busy;
  logic                      kind;
  logic [SLOT_W-1:0]         slot;
  logic signed [LEVEL_W-1:0] level;
  logic                      done;
  logic [CODE_W-1:0]         match_code;

  // local copy of block state
  logic signed [LEVEL_W-1:0] levels_mirror [DEPTH];
  logic [TOL_W-1:0]          tol_mirror;
  logic [COUNT_W-1:0]        count_mirror;

  logic [CODE_W-1:0] code_queue [$];

  int idle_pct;
  int error_count;
  int cycle_count;
  int writes_sent;
  int queries_sent;
  int hits_seen;
  int misses_seen;

  tolerance_window_matcher_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .slot       (slot),
    .level      (level),
    .done       (done),
    .match_code (match_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // First entry strictly inside the band around the query value.
  function automatic logic [CODE_W-1:0] predict_match(input logic signed [LEVEL_W-1:0] v);
    longint q;
    longint band;
    longint r;
    int     n;
    logic [CODE_W-1:0] code;
    q    = v;
    band = (q * longint'(tol_mirror)) / BAND_DIVISOR;
    n    = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
    code = '0;
    for (int i = 0; i < n; i++) begin
      r = levels_mirror[i];
      if (code == '0 && q < r + band && q > r - band)
        code = CODE_W'(i + 1);
    end
    return code;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] random_level();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1000);
      2:       return LEVEL_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return LEVEL_W'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // results are single-cycle pulses; the receiver never stalls
  always @(posedge clk) begin
    logic [CODE_W-1:0] want;
    if (!rst && done) begin
      if (code_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual match_code=%0d",
                 $time, match_code);
        error_count++;
      end else begin
        want = code_queue.pop_front();
        if (match_code !== want) begin
          $display("%0t: match_code mismatch, expected %0d, actual %0d",
                   $time, want, match_code);
          error_count++;
        end
        if (want != '0) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // One command transfer; start stays high after it until the next call.
  task automatic send_item(input logic k, input logic [SLOT_W-1:0] s,
                           input logic signed [LEVEL_W-1:0] lv);
    int gap;
    if (int'($urandom_range(99)) < idle_pct) begin
      gap   = $urandom_range(1, 20);
      start = 1'b0;
      kind  = 1'($urandom);
      slot  = SLOT_W'($urandom);
      level = $urandom;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    kind  = k;
    slot  = s;
    level = lv;
    do @(posedge clk); while (busy);
    if (k == KIND_QUERY) begin
      code_queue.push_back(predict_match(lv));
      queries_sent++;
    end else begin
      levels_mirror[s] = lv;
      writes_sent++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (code_queue.size() != 0) @(negedge clk);
    // a trailing write gives no result, so leave room for a late query walk
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic [PADDR_W-1:0] addr, input logic wr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [PADDR_W-1:0] addr, input int width,
                           input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    logic [PDATA_W-1:0] mask;
    mask = (PDATA_W'(1) << width) - 1;
    apb_access(addr, 1'b0, '0, got);
    if ((got & mask) !== (want & mask)) begin
      $display("%0t: register read at 0x%0h, expected 0x%0h, actual 0x%0h",
               $time, addr, want & mask, got & mask);
      error_count++;
    end
  endtask

  task automatic set_config(input logic [TOL_W-1:0] tol, input logic [COUNT_W-1:0] cnt);
    logic [PDATA_W-1:0] unused;
    drain();
    apb_access(ADDR_TOL, 1'b1, PDATA_W'(tol), unused);
    apb_access(ADDR_COUNT, 1'b1, PDATA_W'(cnt), unused);
    tol_mirror   = tol;
    count_mirror = cnt;
    check_reg(ADDR_TOL, TOL_W, PDATA_W'(tol));
    check_reg(ADDR_COUNT, COUNT_W, PDATA_W'(cnt));
  endtask

  // empty table window right after reset: nothing is read
  task automatic test_reset_state();
    check_reg(ADDR_TOL, TOL_W, '0);
    check_reg(ADDR_COUNT, COUNT_W, '0);
    send_item(KIND_QUERY, 4'd3, 32'sd100);
    send_item(KIND_QUERY, 4'd0, 32'h8000_0000);
  endtask

  task automatic test_table_load();
    logic signed [LEVEL_W-1:0] seed_levels [DEPTH];
    seed_levels = '{32'sd10, 32'sd9, -32'sd50, 32'sd0, 32'sd1000, 32'h7FFF_FFFF,
                    32'h8000_0000, -32'sd1, 32'sd800, 32'sd900, 32'sd1100, 32'sd1200,
                    32'sd1300, 32'sd1400, 32'sd1500, 32'sd123456};
    for (int i = 0; i < DEPTH; i++)
      send_item(KIND_WRITE, SLOT_W'(i), seed_levels[i]);
  endtask

  // strict window edges, negative values, zero and maximum tolerance
  task automatic test_band_edges();
    set_config(16'd10000, 5'd16);
    send_item(KIND_QUERY, 4'd0, 32'sd5);
    send_item(KIND_QUERY, 4'd0, 32'sd0);
    send_item(KIND_QUERY, 4'd15, -32'sd5);
    send_item(KIND_QUERY, 4'd0, 32'sd1000);
    set_config(16'd0, 5'd16);
    send_item(KIND_QUERY, 4'd0, 32'sd10);
    set_config(16'hFFFF, 5'd16);
    send_item(KIND_QUERY, 4'd0, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 4'd0, 32'h8000_0000);
  endtask

  // only the last entry can match; count below and above depth
  task automatic test_count_limits();
    set_config(16'd1, 5'd15);
    send_item(KIND_QUERY, 4'd0, 32'sd123456);
    set_config(16'd1, 5'd31);
    send_item(KIND_QUERY, 4'd0, 32'sd123456);
    set_config(16'd1, 5'd17);
    send_item(KIND_QUERY, 4'd0, 32'sd123460);
    set_config(16'd10000, 5'd1);
    send_item(KIND_QUERY, 4'd0, 32'sd9);
  endtask

  task automatic test_random_traffic();
    logic [TOL_W-1:0]          tol;
    logic [COUNT_W-1:0]        cnt;
    logic signed [LEVEL_W-1:0] v;
    longint r;
    longint b;
    longint q;
    int     lim;
    int     idx;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       begin tol = 16'd10000; cnt = 5'd16; end
        1:       begin tol = 16'd1;     cnt = 5'd16; end
        2:       begin tol = 16'd0;     cnt = 5'd16; end
        3:       begin tol = 16'hFFFF;  cnt = 5'd31; end
        4:       begin tol = 16'd5000;  cnt = 5'd7;  end
        5:       begin tol = 16'd100;   cnt = 5'd1;  end
        6:       begin tol = TOL_W'($urandom); cnt = 5'd17; end
        7:       begin tol = 16'd2500;  cnt = 5'd0;  end
        default: begin tol = TOL_W'($urandom); cnt = COUNT_W'($urandom); end
      endcase
      set_config(tol, cnt);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 57;
        default: idle_pct = 14;
      endcase
      lim = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 25) begin
          send_item(KIND_WRITE, SLOT_W'($urandom), random_level());
        end else if ($urandom_range(99) < 70) begin
          // aim inside or just past the band of an active entry
          idx = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, DEPTH - 1);
          r   = levels_mirror[idx];
          b   = (((r < 0) ? -r : r) * longint'(tol_mirror)) / BAND_DIVISOR + 2;
          if (b > (longint'(1) << 30)) b = longint'(1) << 30;
          q = r + longint'($urandom_range(0, 32'(2 * b))) - b;
          if (q > longint'(32'sh7FFF_FFFF)) q = 32'sh7FFF_FFFF;
          if (q < -(longint'(1) << 31)) q = -(longint'(1) << 31);
          v = LEVEL_W'(q);
          send_item(KIND_QUERY, SLOT_W'($urandom), v);
        end else begin
          send_item(KIND_QUERY, SLOT_W'($urandom), random_level());
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    kind         = KIND_WRITE;
    slot         = '0;
    level        = '0;
    idle_pct     = 0;
    error_count  = 0;
    cycle_count  = 0;
    writes_sent  = 0;
    queries_sent = 0;
    hits_seen    = 0;
    misses_seen  = 0;
    tol_mirror   = '0;
    count_mirror = '0;
    for (int i = 0; i < DEPTH; i++) levels_mirror[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_state();
    test_table_load();
    test_band_edges();
    test_count_limits();
    test_random_traffic();

    drain();
    $display("tb: %0d table writes and %0d queries over %0d config phases",
             writes_sent, queries_sent, RAND_PHASES);
    $display("tb: %0d results with a match, %0d without", hits_seen, misses_seen);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d errors", error_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
